>>> hdl/spwc_pkg.sv
package spwc_pkg;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;   // one squared coordinate difference
  localparam int DIST_W  = 16;   // distances below the hard limit fit here
  localparam int SIZE_W  = 10;
  localparam int GID_W   = 4;
  localparam int BACK_W  = 3;
  localparam int TOTAL_W = 4;

  localparam logic [DIST_W-1:0] DIST_LIMIT     = 16'd35000;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 16'd10000;
  localparam logic [SIZE_W-1:0] COUNT_MAX      = 10'd1023;

  // one point on its way through the distance lanes
  typedef struct packed {
    logic valid;
    logic last;
    logic eligible;   // past warm-up and not the (0,0) marker
  } spwc_item_t;

endpackage

>>> hdl/spwc_dist_lanes.sv
module spwc_dist_lanes
  import spwc_pkg::*;
#(
  parameter int WINDOW = 4,
  localparam int PW = $clog2(WINDOW + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_W-1:0]       in_pos_x,
  input  logic signed [COORD_W-1:0]       in_pos_y,
  input  logic                            in_last_in_scan,
  input  logic                            take,
  output spwc_item_t                      item,
  output logic [WINDOW-1:0]               lane_near,
  output logic [WINDOW-1:0][DIST_W-1:0]   lane_dist
);

  logic signed [COORD_W-1:0] wx_r [WINDOW];
  logic signed [COORD_W-1:0] wy_r [WINDOW];
  logic [PW-1:0]             pos_r;

  spwc_item_t                s1_item_r;
  logic [WINDOW-1:0]         s1_ok_r;
  logic [SQ_W-1:0]           sqx_r [WINDOW];
  logic [SQ_W-1:0]           sqy_r [WINDOW];

  spwc_item_t                s2_item_r;
  logic [WINDOW-1:0]         near_r;
  logic [WINDOW-1:0][DIST_W-1:0] dist_r;

  logic signed [COORD_W:0]     dx [WINDOW];
  logic signed [COORD_W:0]     dy [WINDOW];
  logic signed [2*COORD_W+1:0] px [WINDOW];
  logic signed [2*COORD_W+1:0] py [WINDOW];
  logic [SQ_W:0]               sum [WINDOW];
  logic [WINDOW-1:0]           ok_nxt;
  logic                        accept;
  logic                        s2_load;
  logic                        eligible_nxt;

  assign s2_load  = !s2_item_r.valid || take;
  assign in_ready = !s1_item_r.valid || s2_load;
  assign accept   = in_valid && in_ready;

  assign eligible_nxt = (pos_r >= PW'(WINDOW)) && !(in_pos_x == '0 && in_pos_y == '0);

  // square the differences to every window entry in parallel
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      dx[k]     = {in_pos_x[COORD_W-1], in_pos_x} - {wx_r[k][COORD_W-1], wx_r[k]};
      dy[k]     = {in_pos_y[COORD_W-1], in_pos_y} - {wy_r[k][COORD_W-1], wy_r[k]};
      px[k]     = dx[k] * dx[k];
      py[k]     = dy[k] * dy[k];
      ok_nxt[k] = !(wx_r[k] == '0 && wy_r[k] == '0);
    end
  end

  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      sum[k] = {1'b0, sqx_r[k]} + {1'b0, sqy_r[k]};
    end
  end

  // coordinate window: shift on every accepted word but the last, which clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        wx_r[k] <= '0;
        wy_r[k] <= '0;
      end
      pos_r <= '0;
    end else if (accept) begin
      if (in_last_in_scan) begin
        for (int k = 0; k < WINDOW; k++) begin
          wx_r[k] <= '0;
          wy_r[k] <= '0;
        end
        pos_r <= '0;
      end else begin
        for (int k = WINDOW - 1; k > 0; k--) begin
          wx_r[k] <= wx_r[k-1];
          wy_r[k] <= wy_r[k-1];
        end
        wx_r[0] <= in_pos_x;
        wy_r[0] <= in_pos_y;
        if (pos_r < PW'(WINDOW)) begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r <= '0;
      s2_item_r <= '0;
    end else begin
      if (in_ready) begin
        s1_item_r <= '{valid: in_valid, last: in_last_in_scan, eligible: eligible_nxt};
      end
      if (s2_load) begin
        s2_item_r <= s1_item_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_ok_r <= ok_nxt;
      for (int k = 0; k < WINDOW; k++) begin
        sqx_r[k] <= px[k][SQ_W-1:0];
        sqy_r[k] <= py[k][SQ_W-1:0];
      end
    end
    if (s2_load) begin
      for (int k = 0; k < WINDOW; k++) begin
        near_r[k] <= s1_ok_r[k] && (sum[k] < (SQ_W+1)'(DIST_LIMIT));
        dist_r[k] <= sum[k][DIST_W-1:0];
      end
    end
  end

  assign item      = s2_item_r;
  assign lane_near = near_r;
  assign lane_dist = dist_r;

endmodule

>>> hdl/spwc_group_count.sv
module spwc_group_count
  import spwc_pkg::*;
#(
  parameter int CLUSTERS = 16,
  localparam int LW = $clog2(CLUSTERS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [LW-1:0]     load_addr,
  input  logic              load_new,
  input  logic              load_join,
  input  logic              retire,
  output logic [SIZE_W-1:0] size
);

  logic [SIZE_W-1:0] mem [CLUSTERS];
  logic [SIZE_W-1:0] q_r;
  logic [LW-1:0]     addr_r;
  logic              new_r;
  logic              join_r;
  logic              fwd_r;
  logic [SIZE_W-1:0] fwd_val_r;
  logic [SIZE_W-1:0] base;
  logic [SIZE_W-1:0] inc;

  always_comb begin
    if (new_r) begin
      base = '0;
    end else if (fwd_r) begin
      base = fwd_val_r;
    end else begin
      base = q_r;
    end
    inc  = (base < COUNT_MAX) ? base + 1'b1 : base;
    size = join_r ? inc : '0;
  end

  // write back the count as the word leaves, read the next one's count
  always_ff @(posedge clk) begin
    if (retire && join_r) begin
      mem[addr_r] <= size;
    end
    if (load) begin
      q_r <= mem[load_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (load) begin
      join_r <= load_join;
      // same-edge write and read of one entry: take the written value
      fwd_r  <= retire && join_r && (addr_r == load_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r    <= load_addr;
      new_r     <= load_new;
      fwd_val_r <= size;
    end
  end

endmodule

>>> hdl/scan_point_window_clusterer_core.sv
// Scan point window clusterer.
// Points of one lidar scan enter on the in_ channel (valid/ready) as words of
// pos_x, pos_y and last_in_scan. Each point gets exactly one result word on the
// out_ channel (valid/ready), in order: whether it joined the group of its
// nearest recent neighbor, the group id, whether a group was opened for that
// neighbor and how far back it lies, the joiner count of the group, the number
// of open groups and the stop flag. The cfg_ channel writes max_dist_sq;
// cfg_ready is always high and writes belong in idle periods.
// A point's squares are registered at the accepting edge, then its lane sums,
// then the neighbor pick and count memory read, which raise out_valid; a stall
// can hold the point between these registers.
// Throughput is one point per cycle while the receiver takes results, set by the
// combinational label decision and the read-then-write of the group count memory, which forwards on collisions.
// A stalled receiver holds the output register; the two stages behind it keep
// filling, so in_ready falls only once all three stages hold a word.
// Reset empties the pipeline, clears the window and the group state, and loads
// max_dist_sq with 10000. The count memory needs no clearing pass; a group's
// count is set when the group is opened.
module scan_point_window_clusterer_core
  import spwc_pkg::*;
#(
  parameter int WINDOW   = 4,
  parameter int CLUSTERS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [DIST_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_last_in_scan,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_joined,
  output logic [GID_W-1:0]          out_group_id,
  output logic                      out_new_group,
  output logic [BACK_W-1:0]         out_seed_back,
  output logic [SIZE_W-1:0]         out_joiner_count,
  output logic [TOTAL_W-1:0]        out_group_total,
  output logic                      out_stopped
);

  localparam int LW = $clog2(CLUSTERS);
  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int PW = $clog2(WINDOW + 1);

  spwc_item_t                    item;
  logic [WINDOW-1:0]             lane_near;
  logic [WINDOW-1:0][DIST_W-1:0] lane_dist;

  // window labels, aligned with the decision stage
  logic [WINDOW-1:0]             lab_r;
  logic [WINDOW-1:0][LW-1:0]     label_r;
  logic [LW-1:0]                 go_r;
  logic                          halted_r;
  logic [DIST_W-1:0]             max_dist_r;

  logic                          out_valid_r;
  logic                          joined_r;
  logic [GID_W-1:0]              gid_r;
  logic                          newg_r;
  logic [BACK_W-1:0]             back_r;
  logic [TOTAL_W-1:0]            total_r;
  logic                          stopped_r;

  logic                          move2;
  logic                          retire;

  logic [DIST_W-1:0]             dmin;
  logic [SW-1:0]                 sel;
  logic                          found;
  logic                          hit;
  logic [WINDOW-1:0]             lab_nxt;
  logic [WINDOW-1:0][LW-1:0]     label_nxt;
  logic [LW-1:0]                 go_nxt;
  logic                          halt_nxt;
  logic                          join_nxt;
  logic                          newg_nxt;
  logic [PW-1:0]                 back_nxt;
  logic [LW-1:0]                 g_nxt;
  logic [LW+GID_W-1:0]           gid_ext;
  logic [PW+BACK_W-1:0]          back_ext;
  logic [LW+TOTAL_W-1:0]         total_ext;

  spwc_dist_lanes #(
    .WINDOW (WINDOW)
  ) u_lanes (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_last_in_scan (in_last_in_scan),
    .take            (move2),
    .item            (item),
    .lane_near       (lane_near),
    .lane_dist       (lane_dist)
  );

  // advance the decision stage with a valid item whenever the output register is free or draining
  assign move2     = item.valid && (!out_valid_r || out_ready);
  assign retire    = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  // pick the nearest lane; a tie keeps the more recent point
  always_comb begin
    dmin  = DIST_LIMIT;
    sel   = '0;
    found = 1'b0;
    for (int j = 0; j < WINDOW; j++) begin
      if (lane_near[j] && (lane_dist[j] < dmin)) begin
        dmin  = lane_dist[j];
        sel   = SW'(j);
        found = 1'b1;
      end
    end
    hit = item.eligible && found && (dmin < max_dist_r);
  end

  // label decision: join the neighbor's group, open one for an unlabeled neighbor, or stop the scan
  always_comb begin
    lab_nxt   = lab_r;
    label_nxt = label_r;
    go_nxt    = go_r;
    halt_nxt  = halted_r;
    join_nxt  = 1'b0;
    newg_nxt  = 1'b0;
    back_nxt  = '0;
    g_nxt     = '0;
    if (!halted_r) begin
      if (hit && !lab_r[sel]) begin
        if (go_r >= LW'(CLUSTERS - 1)) begin
          halt_nxt = 1'b1;
        end else begin
          label_nxt[sel] = go_r;
          lab_nxt[sel]   = 1'b1;
          go_nxt         = go_r + 1'b1;
          newg_nxt       = 1'b1;
          back_nxt       = PW'(sel) + 1'b1;
        end
      end
      if (!halt_nxt) begin
        join_nxt = hit;
        g_nxt    = hit ? label_nxt[sel] : '0;
        for (int k = WINDOW - 1; k > 0; k--) begin
          lab_nxt[k]   = lab_nxt[k-1];
          label_nxt[k] = label_nxt[k-1];
        end
        lab_nxt[0]   = join_nxt;
        label_nxt[0] = g_nxt;
      end
    end
    gid_ext   = {{GID_W{1'b0}}, g_nxt};
    back_ext  = {{BACK_W{1'b0}}, back_nxt};
    total_ext = {{TOTAL_W{1'b0}}, go_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= MAX_DIST_RESET;
      lab_r       <= '0;
      go_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_dist_r <= cfg_data;
      end
      if (move2) begin
        // a last point still reports, then drop all group state
        if (item.last) begin
          lab_r    <= '0;
          go_r     <= '0;
          halted_r <= 1'b0;
        end else begin
          lab_r    <= lab_nxt;
          go_r     <= go_nxt;
          halted_r <= halt_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      label_r   <= label_nxt;
      joined_r  <= join_nxt;
      gid_r     <= gid_ext[GID_W-1:0];
      newg_r    <= newg_nxt;
      back_r    <= back_ext[BACK_W-1:0];
      total_r   <= total_ext[TOTAL_W-1:0];
      stopped_r <= halt_nxt;
    end
  end

  spwc_group_count #(
    .CLUSTERS (CLUSTERS)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move2),
    .load_addr (g_nxt),
    .load_new  (newg_nxt),
    .load_join (join_nxt),
    .retire    (retire),
    .size      (out_joiner_count)
  );

  assign out_valid       = out_valid_r;
  assign out_joined      = joined_r;
  assign out_group_id    = gid_r;
  assign out_new_group   = newg_r;
  assign out_seed_back   = back_r;
  assign out_group_total = total_r;
  assign out_stopped     = stopped_r;

  a_new_group_one_joiner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_group |-> out_joined && out_joiner_count == 10'd1)
    else $error("new group must report one joiner");

  a_stopped_not_joined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> !out_joined && !out_new_group)
    else $error("stopped scan must not join points");

  a_unjoined_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_joined |-> out_joiner_count == '0 && out_seed_back == '0)
    else $error("unjoined point must carry zero fields");

  a_groups_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    go_r <= LW'(CLUSTERS - 1))
    else $error("group count past limit");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !(move2 && item.last) |=> halted_r)
    else $error("stop flag dropped before end of scan");

endmodule
